// File: src/jsu_pkg.sv
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
package jsu_pkg;

    // Default number of descriptor slots between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 4;

    // Character codes the decoder reacts to
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    // Surrogate bounds and supplementary plane offset
    localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    // Decoder phases
    typedef enum logic [3:0] {
        PH_AWAIT      = 4'd0,
        PH_BODY       = 4'd1,
        PH_ESC        = 4'd2,
        PH_HEX        = 4'd3,
        PH_AFTER_HIGH = 4'd4,
        PH_HIGH_BS    = 4'd5,
        PH_PAIR_HEX   = 4'd6
    } t_phase;

    // Work for the back part: an optional UTF-8 code point, then an optional
    // single word (byte, done or bad), then an optional trailing bad word
    typedef struct packed {
        logic        utf_en;
        logic [20:0] cp;
        logic [1:0]  utf_len_m1;
        logic        mid_en;
        t_kind       mid_kind;
        logic [7:0]  mid_byte;
        logic        bad_en;
    } t_job;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b inside {[8'h30:8'h39]}) begin
            v = {1'b0, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Single-character escape; bit 8 set when the escape is one of them
    function automatic logic [8:0] esc_decode(input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        case (b)
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_SLASH:  r = {1'b1, CH_SLASH};
            CH_LC_B:   r = {1'b1, 8'h08};
            CH_LC_F:   r = {1'b1, 8'h0C};
            CH_LC_N:   r = {1'b1, 8'h0A};
            CH_LC_R:   r = {1'b1, 8'h0D};
            CH_LC_T:   r = {1'b1, 8'h09};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    // Encoded length minus one of a code point
    function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7F) begin
            n = 2'd0;
        end else if (cp <= 21'h7FF) begin
            n = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Byte k of the UTF-8 encoding of cp
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [1:0]  len_m1,
                                             input logic [1:0]  k);
        logic [7:0] r;
        r = {2'b10, cp[5:0]};
        case (len_m1)
            2'd0: r = cp[7:0];
            2'd1: begin
                if (k == 2'd0) r = {3'b110, cp[10:6]};
            end
            2'd2: begin
                if (k == 2'd0)      r = {4'b1110, cp[15:12]};
                else if (k == 2'd1) r = {2'b10, cp[11:6]};
            end
            default: begin
                if (k == 2'd0)      r = {5'b11110, cp[20:18]};
                else if (k == 2'd1) r = {2'b10, cp[17:12]};
                else if (k == 2'd2) r = {2'b10, cp[11:6]};
            end
        endcase
        return r;
    endfunction

endpackage

// File: src/jsu_front.sv
// Front part: accepts raw words, runs the escape state machine, builds descriptors.
module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    input  logic           i_final_byte,
    input  logic           i_full,
    output logic           o_push,
    output jsu_pkg::t_job  o_job
);

    jsu_pkg::t_phase r_phase, n_phase, s_phase;
    logic [1:0]  r_hex, n_hex, s_hex;
    logic [15:0] r_acc, n_acc, s_acc;
    logic [15:0] r_high, n_high, s_high;
    logic        s_clear;
    logic        step_open;
    logic        accept;

    logic        is_quote, is_bs, is_u;
    logic [8:0]  esc;
    logic [4:0]  hv;
    logic        hex_ok, hex_done;
    logic [15:0] acc_new;
    logic        acc_in_high, acc_in_low;
    logic [20:0] pair_cp;

    logic        utf_en, mid_en, bad_en;
    logic [20:0] cp;
    jsu_pkg::t_kind mid_kind;
    logic [7:0]  mid_byte;

    assign accept = i_valid && !i_full;

    // Classify the incoming word
    assign is_quote    = (i_in_byte == jsu_pkg::CH_QUOTE);
    assign is_bs       = (i_in_byte == jsu_pkg::CH_BSLASH);
    assign is_u        = (i_in_byte == jsu_pkg::CH_LC_U);
    assign esc         = jsu_pkg::esc_decode(i_in_byte);
    assign hv          = jsu_pkg::hex_value(i_in_byte);
    assign hex_ok      = !hv[4];
    assign hex_done    = (r_hex == 2'd3);
    assign acc_new     = {r_acc[11:0], hv[3:0]};
    assign acc_in_high = acc_new inside {[jsu_pkg::HIGH_SUR_LO:jsu_pkg::HIGH_SUR_HI]};
    assign acc_in_low  = acc_new inside {[jsu_pkg::LOW_SUR_LO:jsu_pkg::LOW_SUR_HI]};
    assign pair_cp     = 21'({r_high[9:0], acc_new[9:0]}) + jsu_pkg::SUPP_BASE;

    // Next state for one word, before the end-of-buffer check
    always_comb begin
        s_phase = r_phase;
        s_hex   = r_hex;
        s_acc   = r_acc;
        s_high  = r_high;
        s_clear = 1'b0;
        case (r_phase)
            jsu_pkg::PH_BODY: begin
                if (is_quote)   s_clear = 1'b1;
                else if (is_bs) s_phase = jsu_pkg::PH_ESC;
                else            s_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::PH_ESC: begin
                if (esc[8]) begin
                    s_phase = jsu_pkg::PH_BODY;
                end else if (is_u) begin
                    s_phase = jsu_pkg::PH_HEX;
                    s_hex   = 2'd0;
                    s_acc   = 16'd0;
                end else begin
                    s_clear = 1'b1;
                end
            end
            jsu_pkg::PH_HEX, jsu_pkg::PH_PAIR_HEX: begin
                if (!hex_ok) begin
                    s_clear = 1'b1;
                end else begin
                    s_acc = acc_new;
                    if (hex_done) begin
                        s_hex = 2'd0;
                        if (r_phase == jsu_pkg::PH_HEX && acc_in_high) begin
                            s_high  = acc_new;
                            s_phase = jsu_pkg::PH_AFTER_HIGH;
                        end else begin
                            s_phase = jsu_pkg::PH_BODY;
                        end
                    end else begin
                        s_hex = r_hex + 2'd1;
                    end
                end
            end
            jsu_pkg::PH_AFTER_HIGH: begin
                if (is_bs)         s_phase = jsu_pkg::PH_HIGH_BS;
                else if (is_quote) s_clear = 1'b1;
                else               s_phase = jsu_pkg::PH_BODY;
            end
            jsu_pkg::PH_HIGH_BS: begin
                if (is_u) begin
                    s_phase = jsu_pkg::PH_PAIR_HEX;
                    s_hex   = 2'd0;
                    s_acc   = 16'd0;
                end else if (esc[8]) begin
                    s_phase = jsu_pkg::PH_BODY;
                end else begin
                    s_clear = 1'b1;
                end
            end
            default: begin
                if (is_quote) s_phase = jsu_pkg::PH_BODY;
                else          s_clear = 1'b1;
            end
        endcase
    end

    // Token still open after this word: end of buffer makes it malformed
    assign step_open = !s_clear && (s_phase != jsu_pkg::PH_AWAIT);

    // Drop all state when the token ends
    always_comb begin
        if (s_clear || (i_final_byte && step_open)) begin
            n_phase = jsu_pkg::PH_AWAIT;
            n_hex   = 2'd0;
            n_acc   = 16'd0;
            n_high  = 16'd0;
        end else begin
            n_phase = s_phase;
            n_hex   = s_hex;
            n_acc   = s_acc;
            n_high  = s_high;
        end
    end

    // Descriptor for the results this word causes
    always_comb begin
        utf_en   = 1'b0;
        cp       = 21'd0;
        mid_en   = 1'b0;
        mid_kind = jsu_pkg::KIND_BYTE;
        mid_byte = 8'd0;
        case (r_phase)
            jsu_pkg::PH_BODY: begin
                if (is_quote) begin
                    mid_en   = 1'b1;
                    mid_kind = jsu_pkg::KIND_DONE;
                end else if (!is_bs) begin
                    mid_en   = 1'b1;
                    mid_byte = i_in_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                if (esc[8]) begin
                    mid_en   = 1'b1;
                    mid_byte = esc[7:0];
                end else if (!is_u) begin
                    mid_en   = 1'b1;
                    mid_kind = jsu_pkg::KIND_BAD;
                end
            end
            jsu_pkg::PH_HEX, jsu_pkg::PH_PAIR_HEX: begin
                if (!hex_ok) begin
                    mid_en   = 1'b1;
                    mid_kind = jsu_pkg::KIND_BAD;
                end else if (hex_done) begin
                    if (r_phase == jsu_pkg::PH_PAIR_HEX) begin
                        utf_en = 1'b1;
                        cp     = acc_in_low ? pair_cp : {5'd0, r_high};
                    end else if (!acc_in_high) begin
                        utf_en = 1'b1;
                        cp     = {5'd0, acc_new};
                    end
                end
            end
            jsu_pkg::PH_AFTER_HIGH: begin
                if (!is_bs) begin
                    utf_en = 1'b1;
                    cp     = {5'd0, r_high};
                    mid_en = 1'b1;
                    if (is_quote) mid_kind = jsu_pkg::KIND_DONE;
                    else          mid_byte = i_in_byte;
                end
            end
            jsu_pkg::PH_HIGH_BS: begin
                if (!is_u) begin
                    utf_en = 1'b1;
                    cp     = {5'd0, r_high};
                    mid_en = 1'b1;
                    if (esc[8]) mid_byte = esc[7:0];
                    else        mid_kind = jsu_pkg::KIND_BAD;
                end
            end
            default: begin
                if (!is_quote) begin
                    mid_en   = 1'b1;
                    mid_kind = jsu_pkg::KIND_BAD;
                end
            end
        endcase
        // End of buffer: flush a held high surrogate, then report malformed
        bad_en = i_final_byte && step_open;
        if (bad_en && (s_phase == jsu_pkg::PH_AFTER_HIGH || s_phase == jsu_pkg::PH_HIGH_BS))
        begin
            utf_en = 1'b1;
            cp     = {5'd0, s_high};
        end
    end

    assign o_job.utf_en     = utf_en;
    assign o_job.cp         = cp;
    assign o_job.utf_len_m1 = jsu_pkg::utf8_len_m1(cp);
    assign o_job.mid_en     = mid_en;
    assign o_job.mid_kind   = mid_kind;
    assign o_job.mid_byte   = mid_byte;
    assign o_job.bad_en     = bad_en;
    assign o_push           = accept && (utf_en || mid_en || bad_en);

    // Advance the decoder on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_AWAIT;
            r_hex   <= 2'd0;
            r_acc   <= 16'd0;
            r_high  <= 16'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_acc   <= n_acc;
            r_high  <= n_high;
        end
    end

endmodule

// File: src/jsu_queue.sv
// Descriptor queue between the front and back parts.
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_job   i_job,
    input  logic            i_pop,
    output logic            o_full,
    output jsu_pkg::t_qhead o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store descriptors
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("descriptor pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("descriptor popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: src/jsu_back.sv
// Back part: expands each descriptor into result words, one per cycle while the output is not stalled.
module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jsu_pkg::t_qhead i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_run_end
);

    logic [2:0]     r_pos, n_pos;
    logic           r_o_valid;
    jsu_pkg::t_kind r_kind;
    logic [7:0]     r_byte;
    logic           r_run_end;

    logic [2:0]     utf_cnt, total;
    logic           is_last, load;
    jsu_pkg::t_kind sel_kind;
    logic [7:0]     sel_byte;

    // Count the words of the head descriptor
    assign utf_cnt = i_head.job.utf_en ? ({1'b0, i_head.job.utf_len_m1} + 3'd1) : 3'd0;
    assign total   = utf_cnt + {2'd0, i_head.job.mid_en} + {2'd0, i_head.job.bad_en};
    assign is_last = (r_pos == total - 3'd1);
    assign load    = i_head.valid && (!r_o_valid || !i_stall);
    assign o_pop   = load && is_last;

    // Pick the word at the current position
    always_comb begin
        if (r_pos < utf_cnt) begin
            sel_kind = jsu_pkg::KIND_BYTE;
            sel_byte = jsu_pkg::utf8_byte(i_head.job.cp, i_head.job.utf_len_m1, r_pos[1:0]);
        end else if (r_pos == utf_cnt && i_head.job.mid_en) begin
            sel_kind = i_head.job.mid_kind;
            sel_byte = i_head.job.mid_byte;
        end else begin
            sel_kind = jsu_pkg::KIND_BAD;
            sel_byte = 8'd0;
        end
    end

    assign n_pos = is_last ? 3'd0 : r_pos + 3'd1;

    // Hold the output word while stalled, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos     <= n_pos;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= sel_kind;
            r_byte    <= sel_byte;
            r_run_end <= is_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_kind     = r_kind;
    assign o_out_byte = r_byte;
    assign o_run_end  = r_run_end;

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != 3'd0) |-> i_head.valid)
        else $error("descriptor left the queue before all its words went out");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 3'd4)
        else $error("word position beyond the longest descriptor");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_kind == jsu_pkg::KIND_DONE) |-> r_run_end)
        else $error("string complete not marked as the last word of its run");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_kind != jsu_pkg::KIND_BYTE) |-> (r_byte == 8'd0))
        else $error("status word carries a nonzero byte");

endmodule

// File: src/json_string_unescape_utf8_unit.sv
// JSON string unescaper top level: front decoder, descriptor queue, result sequencer.
//
// Input channel: i_valid / o_stall carry one raw word of a JSON string token,
// i_in_byte, with i_final_byte set on the last word of the buffer. The first
// word of a token is its opening quote.
// Output channel: o_valid / i_stall carry one result word: o_kind (decoded
// byte, string complete, malformed input), o_out_byte, and o_run_end set on
// the last result caused by one input word. Some input words cause none.
// The first result of an input word is registered in the descriptor queue and
// then in the output register before it is valid at the output. Throughput:
// one input word per cycle while each causes at most one result and the
// receiver does not stall; a word that causes N results (up to 5, e.g. a held
// high surrogate, a plain byte and the end of the buffer) holds the output
// sequencer until all N have gone out, and the descriptor queue of QUEUE_DEPTH
// entries lets the decoder run ahead meanwhile.
// o_stall rises only when the descriptor queue is full.
// Reset (synchronous, i_rst_n low) returns the decoder to waiting for an
// opening quote and empties the queue and output register.
// While the receiver stalls, the output word holds and the queue fills.
module json_string_unescape_utf8_unit #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_end
);

    logic            push, pop, full;
    jsu_pkg::t_job   job;
    jsu_pkg::t_qhead head;

    assign o_stall = full;

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .i_final_byte (i_final_byte),
        .i_full       (full),
        .o_push       (push),
        .o_job        (job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_run_end  (o_run_end)
    );

endmodule
